/* hw/rtl/bfrc_pkg.sv */
// ----------------------------------------------------------------------------
// bfrc_pkg
// Operation and status codes and the result record shared by the byte FIFO
// with run count.
// ----------------------------------------------------------------------------
package bfrc_pkg;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Result of one operation, minus the dequeued byte, which arrives from
  // the memory's registered read port in the following cycle.
  typedef struct packed {
    logic       pop_ok;
    logic [1:0] status;
    logic [7:0] entry_count;
    logic       newest_valid;
    logic [7:0] newest_byte;
    logic [7:0] run_length;
  } bfrc_res_t;

endpackage

/* hw/rtl/bfrc_mem.sv */
// ----------------------------------------------------------------------------
// bfrc_mem
// Simple dual-port byte memory: one write port and one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module bfrc_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/bfrc_ctrl.sv */
// ----------------------------------------------------------------------------
// bfrc_ctrl
// Pointer, count and run tracking for the circular byte store. Computes the
// post-operation result of each transaction and drives the memory ports.
// ----------------------------------------------------------------------------
module bfrc_ctrl
  import bfrc_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int CW    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          op_valid,
  input  logic [1:0]    op_kind,
  input  logic [7:0]    op_value,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  output bfrc_res_t     res
);

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] run_r, run_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [7:0]    newest_r, newest_nxt;
  logic [1:0]    status;
  logic          pop_ok;
  logic [CW+7:0] count_ext;
  logic [CW+7:0] run_ext;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    count_nxt  = count_r;
    run_nxt    = run_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    newest_nxt = newest_r;
    status     = ST_OK;
    pop_ok     = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    case (op_kind)
      OP_PUSH: begin
        if (count_r == CW'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          mem_we     = op_valid;
          wr_ptr_nxt = ptr_inc(wr_ptr_r);
          count_nxt  = count_r + 1'b1;
          newest_nxt = op_value;
          // The run grows only while the new byte matches the newest held one.
          if ((count_r != '0) && (op_value == newest_r)) begin
            run_nxt = run_r + 1'b1;
          end else begin
            run_nxt = CW'(1);
          end
        end
      end
      OP_POP: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else begin
          pop_ok     = 1'b1;
          mem_re     = op_valid;
          rd_ptr_nxt = ptr_inc(rd_ptr_r);
          count_nxt  = count_r - 1'b1;
          // Removing the oldest byte can cut the run short.
          if (run_r > count_nxt) begin
            run_nxt = count_nxt;
          end
        end
      end
      OP_CLEAR: begin
        count_nxt  = '0;
        run_nxt    = '0;
        rd_ptr_nxt = wr_ptr_r;
      end
      default: begin
      end
    endcase
  end

  assign mem_waddr = wr_ptr_r;
  assign mem_wdata = op_value;
  assign mem_raddr = rd_ptr_r;

  assign count_ext = {8'd0, count_nxt};
  assign run_ext   = {8'd0, run_nxt};

  always_comb begin
    res.pop_ok       = pop_ok;
    res.status       = status;
    res.entry_count  = count_ext[7:0];
    res.newest_valid = (count_nxt != '0);
    res.newest_byte  = (count_nxt != '0) ? newest_nxt : 8'd0;
    res.run_length   = run_ext[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      run_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else if (op_valid) begin
      count_r  <= count_nxt;
      run_r    <= run_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid) begin
      newest_r <= newest_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r <= count_r) && ((count_r == '0) == (run_r == '0)))
    else $error("run length inconsistent with entry count");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (op_valid && (op_kind == OP_PUSH) && (count_r == CW'(DEPTH)))
      |=> (count_r == CW'(DEPTH)) && $stable(wr_ptr_r))
    else $error("refused enqueue altered the queue");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (op_valid && (op_kind == OP_POP) && (count_r == '0)) |-> !mem_re)
    else $error("memory read issued for a dequeue on an empty queue");
`endif

endmodule

/* hw/rtl/byte_fifo_with_run_count.sv */
// ----------------------------------------------------------------------------
// byte_fifo_with_run_count
// Fixed-depth byte FIFO held in a circular memory, reporting entry count,
// newest byte and the run of equal bytes from the newest entry.
//
//   channel  | direction | tdata                          | tuser
//   ---------+-----------+--------------------------------+-------
//   in_      | slave     | value                          | kind
//   out_     | master    | read_byte .. run_length (40 b) | none
//
// One transaction is accepted per cycle while the input is not stalled; its
// result is registered first beside the read port of the byte memory, then in
// the output register. Reset is synchronous and active low; it empties the queue,
// the stored bytes are left as they are and need no clearing pass.
// A stalled output holds one result and one result in flight; the input stalls
// only while both are occupied.
// ----------------------------------------------------------------------------
module byte_fifo_with_run_count
  import bfrc_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] value
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_byte, [9:8] status, [17:10] entry_count, [18] newest_valid,
  // [26:19] newest_byte, [34:27] run_length, [39:35] zero
  output logic [39:0] out_tdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic          in_accept;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  bfrc_res_t     res;

  bfrc_res_t     s1_res_r;
  logic          s1_valid_r;
  logic          s1_move;
  logic          out_valid_r;
  logic [39:0]   out_data_r, out_data_nxt;
  logic [7:0]    read_byte;

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_accept = in_tvalid && in_tready;

  bfrc_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (in_accept),
    .op_kind   (in_tuser),
    .op_value  (in_tdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  bfrc_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The dequeued byte joins the rest of the result once the memory answers.
  assign read_byte    = s1_res_r.pop_ok ? mem_rdata : 8'd0;
  assign out_data_nxt = {5'd0, s1_res_r.run_length, s1_res_r.newest_byte,
                         s1_res_r.newest_valid, s1_res_r.entry_count,
                         s1_res_r.status, read_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_res_r <= res;
    end
    if (s1_move) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while both result slots are full");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_move) |=> s1_valid_r && $stable(s1_res_r))
    else $error("pending result lost while output stalled");

  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("result moved but output not valid");
`endif

endmodule

/* tb/byte_fifo_with_run_count_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_fifo_with_run_count_tb
// Drives enqueue, dequeue, clear and unused operations into the byte FIFO and
// compares every result against a queue-based model of the circular-memory
// FIFO. Both stream sides idle at random, the result side is held off long
// enough to stall the input, and the queue is driven to full and to empty.
// ----------------------------------------------------------------------------
module byte_fifo_with_run_count_tb;
  import bfrc_pkg::*;

  localparam int FIFO_DEPTH = 128;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [1:0] status;
    logic [7:0] entry_count;
    logic       newest_valid;
    logic [7:0] newest_byte;
    logic [7:0] run_length;
  } fifo_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] value
  logic [1:0]  in_tuser;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready;
  // [7:0] read_byte, [9:8] status, [17:10] entry_count, [18] newest_valid,
  // [26:19] newest_byte, [34:27] run_length, [39:35] zero
  logic [39:0] out_tdata;

  // Model of the stored bytes, index 0 is the newest entry.
  logic [7:0]   held_bytes[$];
  fifo_result_t pending_results[$];
  int           err_count;
  int           send_gap_max;
  int           recv_gap_max;
  int           recv_hold_request;
  logic [7:0]   last_pick;

  byte_fifo_with_run_count #(
    .DEPTH(FIFO_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("byte_fifo_with_run_count_tb: done, errors");
    $finish;
  end

  // Applies one operation to the model and returns the result it reports.
  function automatic fifo_result_t fifo_apply(input logic [1:0] op, input logic [7:0] data);
    fifo_result_t r;
    int           n;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (held_bytes.size() >= FIFO_DEPTH) r.status = ST_FULL;
        else held_bytes.push_front(data);
      end
      OP_POP: begin
        if (held_bytes.size() == 0) r.status = ST_EMPTY;
        else r.read_byte = held_bytes.pop_back();
      end
      OP_CLEAR: held_bytes.delete();
      default: ;
    endcase
    r.entry_count  = 8'(held_bytes.size());
    r.newest_valid = (held_bytes.size() != 0);
    if (held_bytes.size() != 0) begin
      r.newest_byte = held_bytes[0];
      n = 1;
      while (n < held_bytes.size() && held_bytes[n] == held_bytes[0]) n++;
      r.run_length = 8'(n);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
    err_count++;
    if (err_count <= 10)
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, exp_v, act_v);
  endtask

  // Predicts on every accepted operation and checks every accepted result.
  always @(posedge clk) begin : scoreboard
    fifo_result_t exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: result %0h with none expected", $realtime, out_tdata);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_tdata[7:0] !== exp_r.read_byte)
            report_mismatch("read_byte", exp_r.read_byte, out_tdata[7:0]);
          if (out_tdata[9:8] !== exp_r.status)
            report_mismatch("status", 8'(exp_r.status), 8'(out_tdata[9:8]));
          if (out_tdata[17:10] !== exp_r.entry_count)
            report_mismatch("entry_count", exp_r.entry_count, out_tdata[17:10]);
          if (out_tdata[18] !== exp_r.newest_valid)
            report_mismatch("newest_valid", 8'(exp_r.newest_valid), 8'(out_tdata[18]));
          if (out_tdata[26:19] !== exp_r.newest_byte)
            report_mismatch("newest_byte", exp_r.newest_byte, out_tdata[26:19]);
          if (out_tdata[34:27] !== exp_r.run_length)
            report_mismatch("run_length", exp_r.run_length, out_tdata[34:27]);
          if (out_tdata[39:35] !== 5'd0)
            report_mismatch("padding", 8'd0, 8'(out_tdata[39:35]));
        end
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(fifo_apply(in_tuser, in_tdata));
    end
  end

  // Result side: a random wait before each transaction, or a long hold-off
  // when a test asks for one.
  initial begin : result_sink
    int wait_cycles;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (recv_hold_request > 0) begin
        wait_cycles = recv_hold_request;
        recv_hold_request = 0;
      end else begin
        wait_cycles = $urandom_range(0, recv_gap_max);
      end
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_op(input logic [1:0] op, input logic [7:0] data);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Favors repeats of the last byte so that runs build up.
  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) ;
    else if (sel < 75) last_pick = 8'h55 << $urandom_range(0, 1) ^ {8{sel[0]}};
    else last_pick = 8'($urandom);
    return last_pick;
  endfunction

  task automatic test_directed();
    send_op(OP_POP,   8'hFF);  // dequeue when empty
    send_op(OP_NONE,  8'hA5);  // unused kind on an empty queue
    send_op(OP_CLEAR, 8'h00);  // clear when already empty
    send_op(OP_PUSH,  8'h00);
    send_op(OP_PUSH,  8'hFF);
    send_op(OP_PUSH,  8'hFF);
    send_op(OP_PUSH,  8'hFF);
    send_op(OP_NONE,  8'h5A);
    send_op(OP_PUSH,  8'h80);
    send_op(OP_PUSH,  8'h01);
    send_op(OP_PUSH,  8'h01);
    send_op(OP_POP,   8'h00);
    send_op(OP_POP,   8'h7F);
    send_op(OP_POP,   8'h00);
    send_op(OP_CLEAR, 8'hFF);
    send_op(OP_POP,   8'h00);  // dequeue right after clear
    send_op(OP_PUSH,  8'hAA);
    send_op(OP_POP,   8'h00);
    send_op(OP_POP,   8'h00);
    send_op(OP_PUSH,  8'h55);
    send_op(OP_PUSH,  8'h55);
    send_op(OP_NONE,  8'hFF);
    send_op(OP_CLEAR, 8'h00);
  endtask

  // One run of equal bytes over the whole depth, then full and empty refusals.
  task automatic test_full_queue();
    send_gap_max = 0;
    recv_gap_max = 0;
    send_op(OP_CLEAR, 8'h00);
    repeat (FIFO_DEPTH) send_op(OP_PUSH, 8'h5A);
    send_op(OP_PUSH, 8'hFF);
    send_op(OP_PUSH, 8'h00);
    send_op(OP_NONE, 8'h3C);
    send_op(OP_POP, 8'h00);
    send_op(OP_PUSH, 8'hC3);
    send_op(OP_PUSH, 8'hC3);
    send_gap_max = 19;
    recv_gap_max = 19;
    repeat (FIFO_DEPTH + 1) send_op(OP_POP, 8'($urandom));
  endtask

  // The result side stops for a long stretch while operations keep coming.
  task automatic test_output_stall();
    send_gap_max = 0;
    recv_hold_request = 250;
    repeat (40) send_op($urandom_range(0, 2) == 0 ? OP_POP : OP_PUSH, pick_byte());
    wait_results_drained();
    repeat (20) send_op(OP_PUSH, pick_byte());
    send_gap_max = 19;
  endtask

  task automatic test_random_ops();
    int   sel;
    int   push_pct;
    logic fill_phase;
    for (int phase = 0; phase < 8; phase++) begin
      fill_phase   = (phase % 2 == 0);
      push_pct     = fill_phase ? 72 : 30;
      send_gap_max = (phase % 3 == 1) ? 0 : 19;
      recv_gap_max = (phase % 4 == 2) ? 0 : 19;
      repeat (140) begin
        sel = $urandom_range(0, 99);
        if (sel < push_pct) send_op(OP_PUSH, pick_byte());
        else if (sel < 94) send_op(OP_POP, 8'($urandom));
        else if (sel < 96) send_op(OP_CLEAR, 8'($urandom));
        else send_op(OP_NONE, 8'($urandom));
      end
      // After phases 2 and 5 the sender waits here until every result is back.
      if (phase % 3 == 2) wait_results_drained();
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_tvalid         = 1'b0;
    in_tdata          = '0;
    in_tuser          = OP_PUSH;
    err_count         = 0;
    send_gap_max      = 19;
    recv_gap_max      = 19;
    recv_hold_request = 0;
    last_pick         = 8'h00;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_queue();
    test_output_stall();
    test_random_ops();

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("byte_fifo_with_run_count_tb: done, clean");
    end else begin
      $display("byte_fifo_with_run_count_tb: done, errors");
    end
    $finish;
  end

endmodule
